// File: rtl/lzs_pkg.sv
// shared types, constants and codes for the lzs stream decompressor
// no dependencies; imported by lzs_decoder and lzs_stream_decompressor
package lzs_pkg;

    // defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 2048;
    localparam int LENGTH_BITS_DEF   = 16;

    // bit-field sizes of the token syntax
    localparam int ACC_W     = 11;
    localparam int CNT_W     = 4;
    localparam int BYTE_W    = 8;
    localparam logic [CNT_W-1:0] LIT_BITS   = 4'd8;
    localparam logic [CNT_W-1:0] OFF7_BITS  = 4'd7;
    localparam logic [CNT_W-1:0] OFF11_BITS = 4'd11;
    localparam logic [CNT_W-1:0] LEN2_BITS  = 4'd2;
    localparam logic [CNT_W-1:0] LENX_BITS  = 4'd4;
    localparam logic [1:0]       LEN_CODE_ESC = 2'd3;
    localparam logic [3:0]       LEN_GROUP_MORE = 4'hf;

    // operation codes
    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // bit parser phases
    typedef enum logic [2:0] {
        PH_TYPE,
        PH_OTYPE,
        PH_LIT,
        PH_OFF7,
        PH_OFF11,
        PH_LENA,
        PH_LENB,
        PH_LENX
    } phase_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] in_byte;
    } item_t;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              accepted;
        logic              copy_pending;
        logic              finished;
        logic              bad_offset;
    } result_t;

    // decoder to pipeline: what one transaction does to the history and the result
    typedef struct packed {
        logic              emit;
        logic              from_mem;
        logic [BYTE_W-1:0] data;
        logic              accepted;
        logic              copy_pending;
        logic              finished;
        logic              bad_offset;
    } step_t;

endpackage

// File: rtl/lzs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/lzs_decoder.sv
// bit parser and control state: decodes one compressed byte per transaction,
// tracks the pending copy and computes history addresses; uses lzs_pkg
module lzs_decoder #(
    parameter int HISTORY_DEPTH = lzs_pkg::HISTORY_DEPTH_DEF,
    parameter int LENGTH_BITS   = lzs_pkg::LENGTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  lzs_pkg::item_t                   item,
    output lzs_pkg::step_t                   step,
    output logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] waddr
);
    import lzs_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int BW_W = $clog2(HISTORY_DEPTH + 1);
    localparam int LB   = LENGTH_BITS;

    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  off_reg, off_next;
    logic [LB-1:0]     rem_reg, rem_next;
    logic [LB-1:0]     lacc_reg, lacc_next;
    logic              end_reg, end_next;
    logic              err_reg, err_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [BW_W-1:0]   bw_reg, bw_next;

    logic              lit_done;
    logic [BYTE_W-1:0] lit_byte;
    logic              feed_ok;
    logic              copy_go;
    logic [AW:0]       back_sum;

    assign feed_ok = (item.op == OP_FEED) && (rem_reg == '0) && !end_reg;
    assign copy_go = (item.op == OP_ADVANCE) && (rem_reg != '0);

    // parser: eight bits of the byte, most significant first
    always_comb
    begin
        logic             b;
        logic [ACC_W-1:0] a;
        logic             fin;
        logic [LB-1:0]    fin_len;
        logic [LB:0]      sum;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        lacc_next  = lacc_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        lit_done   = 1'b0;
        lit_byte   = '0;
        b          = 1'b0;
        a          = '0;
        fin        = 1'b0;
        fin_len    = '0;
        sum        = '0;

        if (feed_ok)
        begin
            for (int i = BYTE_W - 1; i >= 0; i--)
            begin
                if (!end_next)
                begin
                    b   = item.in_byte[i];
                    fin = 1'b0;
                    case (phase_next)
                        PH_TYPE:
                        begin
                            phase_next = b ? PH_OTYPE : PH_LIT;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        PH_OTYPE:
                        begin
                            phase_next = b ? PH_OFF7 : PH_OFF11;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            a        = {acc_next[ACC_W-2:0], b};
                            acc_next = a;
                            cnt_next = cnt_next + 1'b1;
                            case (phase_next)
                                PH_LIT:
                                begin
                                    if (cnt_next == LIT_BITS)
                                    begin
                                        lit_done   = 1'b1;
                                        lit_byte   = a[BYTE_W-1:0];
                                        phase_next = PH_TYPE;
                                        acc_next   = '0;
                                        cnt_next   = '0;
                                    end
                                end
                                PH_OFF7:
                                begin
                                    if (cnt_next == OFF7_BITS)
                                    begin
                                        // zero short offset is the end marker
                                        if (a == '0)
                                        begin
                                            end_next   = 1'b1;
                                            phase_next = PH_TYPE;
                                        end
                                        else
                                        begin
                                            off_next   = a;
                                            phase_next = PH_LENA;
                                        end
                                        acc_next = '0;
                                        cnt_next = '0;
                                    end
                                end
                                PH_OFF11:
                                begin
                                    if (cnt_next == OFF11_BITS)
                                    begin
                                        off_next   = a;
                                        phase_next = PH_LENA;
                                        acc_next   = '0;
                                        cnt_next   = '0;
                                    end
                                end
                                PH_LENA:
                                begin
                                    if (cnt_next == LEN2_BITS)
                                    begin
                                        if (a[1:0] != LEN_CODE_ESC)
                                        begin
                                            fin     = 1'b1;
                                            fin_len = LB'(2) + LB'(a[1:0]);
                                        end
                                        else
                                        begin
                                            phase_next = PH_LENB;
                                            acc_next   = '0;
                                            cnt_next   = '0;
                                        end
                                    end
                                end
                                PH_LENB:
                                begin
                                    if (cnt_next == LEN2_BITS)
                                    begin
                                        if (a[1:0] != LEN_CODE_ESC)
                                        begin
                                            fin     = 1'b1;
                                            fin_len = LB'(5) + LB'(a[1:0]);
                                        end
                                        else
                                        begin
                                            lacc_next  = LB'(8);
                                            phase_next = PH_LENX;
                                            acc_next   = '0;
                                            cnt_next   = '0;
                                        end
                                    end
                                end
                                PH_LENX:
                                begin
                                    if (cnt_next == LENX_BITS)
                                    begin
                                        // saturating add of one extension group
                                        sum = {1'b0, lacc_next} + (LB+1)'(a[3:0]);
                                        lacc_next = sum[LB] ? {LB{1'b1}} : sum[LB-1:0];
                                        if (a[3:0] != LEN_GROUP_MORE)
                                        begin
                                            fin     = 1'b1;
                                            fin_len = lacc_next;
                                        end
                                        else
                                        begin
                                            acc_next = '0;
                                            cnt_next = '0;
                                        end
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_TYPE;
                                    acc_next   = '0;
                                    cnt_next   = '0;
                                end
                            endcase
                        end
                    endcase

                    if (fin)
                    begin
                        // offset check against the bytes written before this byte
                        if ((off_next == '0) ||
                            ({{(BW_W-ACC_W){1'b0}}, off_next} > bw_reg))
                        begin
                            err_next = 1'b1;
                            off_next = '0;
                        end
                        rem_next   = fin_len;
                        phase_next = PH_TYPE;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
            end
        end
        else if (copy_go)
        begin
            rem_next = rem_reg - 1'b1;
        end
    end

    // history addressing and result flags
    assign back_sum = {1'b0, wp_reg} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(off_reg);

    always_comb
    begin
        step     = '0;
        wp_next  = wp_reg;
        bw_next  = bw_reg;
        waddr    = wp_reg;
        raddr    = (back_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                   AW'(back_sum - (AW+1)'(HISTORY_DEPTH)) : back_sum[AW-1:0];

        step.accepted = feed_ok;
        if (lit_done || copy_go)
        begin
            step.emit     = 1'b1;
            step.from_mem = copy_go && (off_reg != '0);
            step.data     = lit_done ? lit_byte : '0;
            wp_next       = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (bw_reg < BW_W'(HISTORY_DEPTH))
            begin
                bw_next = bw_reg + 1'b1;
            end
        end
        step.copy_pending = (rem_next != '0);
        step.finished     = end_next;
        step.bad_offset   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            off_reg   <= '0;
            rem_reg   <= '0;
            lacc_reg  <= '0;
            end_reg   <= 1'b0;
            err_reg   <= 1'b0;
            wp_reg    <= '0;
            bw_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
            lacc_reg  <= lacc_next;
            end_reg   <= end_next;
            err_reg   <= err_next;
            wp_reg    <= wp_next;
            bw_reg    <= bw_next;
        end
    end

endmodule

// File: rtl/lzs_stream_decompressor.sv
// lzs (stac) stream decompressor top level: decoder, history ram, read stage
// with forwarding and the result register; uses lzs_pkg, lzs_decoder, lzs_ram
//
// usage
//   item channel (item_valid/item_ready/item): op feed hands in one compressed
//   byte, op advance asks for one byte of a pending copy. every transaction on
//   the item channel produces exactly one transaction on the result channel
//   (result_valid/result_ready/result), in order.
//   a feed is refused (result.accepted low) while a copy is pending or after
//   the end marker; the caller then issues advance transactions until
//   result.copy_pending drops.
//   path: an accepted item first sits in the read stage (decode and history
//   read issue), then moves to the result register (read data, write back),
//   which presents its result.
//   throughput: one item per cycle sustained while result_ready stays high, also
//   for back-to-back copy bytes with offset one; the single history ram port
//   pair (one read, one write per cycle) sets that figure, and a write-to-read
//   forward covers a read of the entry being written in the same cycle.
//   reset: parser returns to token start, pointers, counts and flags clear.
//   the history ram is not cleared; an offset beyond the bytes written so far
//   is flagged and copies zeros, so unwritten entries are never read.
//   receiver stall: the result register holds; the read stage holds one more
//   item, after which item_ready drops until the result is taken.
module lzs_stream_decompressor #(
    parameter int HISTORY_DEPTH = lzs_pkg::HISTORY_DEPTH_DEF,
    parameter int LENGTH_BITS   = lzs_pkg::LENGTH_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  lzs_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output lzs_pkg::result_t result
);
    import lzs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    // decode stage
    logic              take;
    step_t             step;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;

    // read stage: item waiting for ram data, write back on exit
    logic              s2_v_reg;
    step_t             s2_step_reg;
    logic [AW-1:0]     s2_waddr_reg;
    logic              s2_fwd_reg;
    logic [BYTE_W-1:0] s2_fwd_data_reg;
    logic              s2_move;
    logic [BYTE_W-1:0] rdata;
    logic [BYTE_W-1:0] s2_byte;
    logic              fwd_hit;

    // result register
    logic              res_v_reg;
    result_t           res_reg;

    assign s2_move    = s2_v_reg && (!res_v_reg || result_ready);
    assign item_ready = !s2_v_reg || s2_move;
    assign take       = item_valid && item_ready;

    lzs_decoder #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .step  (step),
        .raddr (raddr),
        .waddr (waddr)
    );

    // copied byte: forwarded write, ram data, or literal / zero from decode
    always_comb
    begin
        if (s2_step_reg.from_mem)
        begin
            s2_byte = s2_fwd_reg ? s2_fwd_data_reg : rdata;
        end
        else
        begin
            s2_byte = s2_step_reg.data;
        end
    end

    // read of the entry that the exiting item writes this cycle
    assign fwd_hit = s2_move && s2_step_reg.emit && (s2_waddr_reg == raddr);

    lzs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (s2_move && s2_step_reg.emit),
        .waddr (s2_waddr_reg),
        .wdata (s2_byte),
        .re    (take && step.from_mem),
        .raddr (raddr),
        .rdata (rdata)
    );

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (take)
        begin
            s2_v_reg <= 1'b1;
        end
        else if (s2_move)
        begin
            s2_v_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_step_reg     <= step;
            s2_waddr_reg    <= waddr;
            s2_fwd_reg      <= fwd_hit;
            s2_fwd_data_reg <= s2_byte;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            res_v_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_v_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            res_reg.out_valid    <= s2_step_reg.emit;
            res_reg.out_byte     <= s2_step_reg.emit ? s2_byte : '0;
            res_reg.accepted     <= s2_step_reg.accepted;
            res_reg.copy_pending <= s2_step_reg.copy_pending;
            res_reg.finished     <= s2_step_reg.finished;
            res_reg.bad_offset   <= s2_step_reg.bad_offset;
        end
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule

// File: tb/lzs_stream_decompressor_test.sv
// self-checking testbench for the lzs stream decompressor: builds lzs bitstreams,
// feeds them through the item channel and checks every result against a predictor
// depends on rtl/lzs_pkg.sv and rtl/lzs_stream_decompressor.sv
module lzs_stream_decompressor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzs_pkg::*;

    localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
    localparam int LEN_LIMIT  = (1 << LENGTH_BITS_DEF) - 1;

    // clock, reset and the two channels
    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    lzs_stream_decompressor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // decoder predictor: its own copy of history, parser and copy state
    // ------------------------------------------------------------------
    bit [7:0]    hist_mem [HIST_DEPTH];
    bit [10:0]   wr_ptr;
    int unsigned n_written;      // saturates at the history depth
    phase_t      parse_ph;
    bit [10:0]   field_acc;
    int unsigned field_bits;
    bit [10:0]   copy_offset;    // zero once flagged, copy then emits zeros
    int unsigned copy_left;
    int unsigned run_len;        // running sum of the extended length groups
    bit          end_flag;
    bit          offset_flag;

    // expected results, oldest first
    result_t     decoded_queue[$];

    // run control shared by the stimulus, the receiver and the checker
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned noise_pct;
    int unsigned hold_target;
    int unsigned hold_count;
    int unsigned useful_items;
    int unsigned error_count;

    // compressed bits not yet packed into a fed byte, oldest first
    bit          stream_bits[$];

    function automatic void clear_model();
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        wr_ptr      = '0;
        n_written   = 0;
        parse_ph    = PH_TYPE;
        field_acc   = '0;
        field_bits  = 0;
        copy_offset = '0;
        copy_left   = 0;
        run_len     = 0;
        end_flag    = 1'b0;
        offset_flag = 1'b0;
    endfunction

    function automatic void store_out(bit [7:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;    // 11 bits wrap at the history depth
        if (n_written < HIST_DEPTH)
            n_written++;
    endfunction

    function automatic void enter_phase(phase_t p);
        parse_ph   = p;
        field_acc  = '0;
        field_bits = 0;
    endfunction

    function automatic void close_match(int unsigned len);
        if (len > LEN_LIMIT)
            len = LEN_LIMIT;
        if (copy_offset == 0 || copy_offset > n_written)
        begin
            offset_flag = 1'b1;
            copy_offset = '0;
        end
        copy_left = len;
        enter_phase(PH_TYPE);
    endfunction

    // one compressed bit; returns 1 when a literal completes
    function automatic bit decode_bit(bit b, output bit [7:0] lit);
        bit [10:0] v;
        lit = '0;
        case (parse_ph)
            PH_TYPE:
            begin
                enter_phase(b ? PH_OTYPE : PH_LIT);
                return 1'b0;
            end
            PH_OTYPE:
            begin
                enter_phase(b ? PH_OFF7 : PH_OFF11);
                return 1'b0;
            end
            default: ;
        endcase
        field_acc = {field_acc[9:0], b};
        field_bits++;
        v = field_acc;
        case (parse_ph)
            PH_LIT:
            if (field_bits == 8)
            begin
                lit = v[7:0];
                store_out(lit);
                enter_phase(PH_TYPE);
                return 1'b1;
            end
            PH_OFF7:
            if (field_bits == 7)
            begin
                // zero short offset is the end marker
                if (v == 0)
                begin
                    end_flag = 1'b1;
                    enter_phase(PH_TYPE);
                end
                else
                begin
                    copy_offset = v;
                    enter_phase(PH_LENA);
                end
            end
            PH_OFF11:
            if (field_bits == 11)
            begin
                copy_offset = v;
                enter_phase(PH_LENA);
            end
            PH_LENA:
            if (field_bits == 2)
            begin
                if (v < 3)
                    close_match(2 + v);
                else
                    enter_phase(PH_LENB);
            end
            PH_LENB:
            if (field_bits == 2)
            begin
                if (v < 3)
                    close_match(5 + v);
                else
                begin
                    run_len = 8;
                    enter_phase(PH_LENX);
                end
            end
            PH_LENX:
            if (field_bits == 4)
            begin
                run_len += v;
                if (run_len > LEN_LIMIT)
                    run_len = LEN_LIMIT;
                if (v != 15)
                    close_match(run_len);
                else
                    enter_phase(PH_LENX);
            end
            default: enter_phase(PH_TYPE);
        endcase
        return 1'b0;
    endfunction

    // what one accepted item transaction should produce
    function automatic result_t decode_item(item_t it);
        result_t   r;
        bit [7:0]  lit;
        bit [10:0] src;
        r = '0;
        if (it.op == OP_FEED)
        begin
            if (copy_left == 0 && !end_flag)
            begin
                r.accepted = 1'b1;
                // bits left in the byte after the end marker are dropped
                for (int i = 7; i >= 0; i--)
                begin
                    if (!end_flag)
                    begin
                        if (decode_bit(it.in_byte[i], lit))
                        begin
                            r.out_valid = 1'b1;
                            r.out_byte  = lit;
                        end
                    end
                end
            end
        end
        else if (copy_left != 0)
        begin
            src = wr_ptr - copy_offset;
            r.out_byte  = (copy_offset != 0) ? hist_mem[src] : 8'h00;
            r.out_valid = 1'b1;
            store_out(r.out_byte);
            copy_left--;
        end
        r.copy_pending = (copy_left != 0);
        r.finished     = end_flag;
        r.bad_offset   = offset_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls plus a counted hold-off for back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_count < hold_target)
        begin
            result_ready <= 1'b0;
            hold_count++;
        end
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // checker: every result transaction against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_result(result_t got);
        result_t want;
        if (decoded_queue.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: result with no expectation: valid=%0b byte=%02h %s",
                         $realtime, got.out_valid, got.out_byte,
                         $sformatf("acc=%0b pend=%0b fin=%0b bad=%0b",
                                   got.accepted, got.copy_pending,
                                   got.finished, got.bad_offset));
            return;
        end
        want = decoded_queue.pop_front();
        if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
            got.accepted !== want.accepted || got.copy_pending !== want.copy_pending ||
            got.finished !== want.finished || got.bad_offset !== want.bad_offset)
        begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: mismatch exp %s, got %s", $realtime,
                         $sformatf("valid=%0b byte=%02h acc=%0b pend=%0b fin=%0b bad=%0b",
                                   want.out_valid, want.out_byte, want.accepted,
                                   want.copy_pending, want.finished, want.bad_offset),
                         $sformatf("valid=%0b byte=%02h acc=%0b pend=%0b fin=%0b bad=%0b",
                                   got.out_valid, got.out_byte, got.accepted,
                                   got.copy_pending, got.finished, got.bad_offset));
        end
    endtask

    // values sampled at the edge are the ones from before it
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_ready === 1'b1)
            check_result(result);
    end

    // ------------------------------------------------------------------
    // sender: one item transaction, prediction taken at acceptance
    // ------------------------------------------------------------------
    task automatic send_item(logic op, logic [7:0] data);
        item_t   it;
        result_t r;
        it.op      = op;
        it.in_byte = data;
        // random gaps with valid low; valid stays high between back-to-back items
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_ready !== 1'b1)
            @(posedge clk);
        r = decode_item(it);
        decoded_queue.insert(decoded_queue.size(), r);
        if (r.accepted || r.out_valid)
            useful_items++;
    endtask

    // ------------------------------------------------------------------
    // bitstream builder
    // ------------------------------------------------------------------
    function automatic void put_field(int value, int width);
        for (int i = width - 1; i >= 0; i--)
            stream_bits.insert(stream_bits.size(), value[i]);
    endfunction

    function automatic void put_literal(int value);
        put_field(0, 1);
        put_field(value, 8);
    endfunction

    // short form carries a 7-bit offset, long form an 11-bit one
    function automatic void put_match(int offset, int len, bit short_form);
        int rest;
        if (short_form)
        begin
            put_field(3, 2);
            put_field(offset, 7);
        end
        else
        begin
            put_field(2, 2);
            put_field(offset, 11);
        end
        if (len <= 4)
            put_field(len - 2, 2);
        else if (len <= 7)
        begin
            put_field(3, 2);
            put_field(len - 5, 2);
        end
        else
        begin
            put_field(15, 4);
            rest = len - 8;
            while (rest >= 15)
            begin
                put_field(15, 4);
                rest -= 15;
            end
            put_field(rest, 4);
        end
    endfunction

    // advance transactions until the copy is done, with refused feeds mixed in
    task automatic finish_copy();
        while (copy_left != 0)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(OP_FEED, 8'($urandom));
            send_item(OP_ADVANCE, 8'($urandom));
        end
    endtask

    // feed every whole byte of the stream; leftover bits wait for more tokens
    task automatic pump();
        logic [7:0] data;
        while (stream_bits.size() >= 8)
        begin
            finish_copy();
            if ($urandom_range(99) < noise_pct)
                send_item(OP_ADVANCE, 8'($urandom));    // nothing pending, ignored
            for (int i = 0; i < 8; i++)
                data = {data[6:0], stream_bits.pop_front()};
            send_item(OP_FEED, data);
        end
        finish_copy();
    endtask

    // one random token; offsets stay within what has been written, but for a zero long offset
    task automatic random_token();
        int lim;
        int len;
        int roll;
        bit short_form;
        if (n_written == 0 || $urandom_range(99) < 45)
        begin
            put_literal($urandom_range(255));
            return;
        end
        roll = $urandom_range(99);
        if (roll < 70)
            len = $urandom_range(7, 2);
        else if (roll < 95)
            len = $urandom_range(40, 8);
        else
            len = $urandom_range(300, 41);
        if ($urandom_range(99) < 2)
        begin
            put_match(0, len, 1'b0);    // zero long offset, flagged
            return;
        end
        short_form = 1'($urandom_range(1));
        lim = short_form ? 127 : 2047;
        if (n_written < lim)
            lim = n_written;
        put_match($urandom_range(lim, 1), len, short_form);
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // literal extremes and an advance with no copy pending
    task automatic test_literals();
        send_item(OP_ADVANCE, 8'hff);
        put_literal(8'h00);
        put_literal(8'hff);
        put_literal(8'h80);
        put_literal(8'h01);
        pump();
    endtask

    // every length code, both offset forms, extension groups; feeds refused mid-copy
    task automatic test_match_lengths();
        noise_pct = 40;
        for (int len = 2; len <= 7; len++)
            put_match(1 + (len % 3), len, len[0]);
        put_match(3, 8, 1'b0);      // extension group of zero
        put_match(2, 22, 1'b1);     // one group of fourteen
        put_match(4, 23, 1'b0);     // all-ones group followed by a zero group
        pump();
        noise_pct = 5;
    endtask

    // offset beyond the bytes written, and a zero long offset; both copy zeros
    task automatic test_bad_offsets();
        put_match(2047, 3, 1'b0);
        put_match(0, 2, 1'b0);
        put_literal(8'h3c);
        pump();
    endtask

    task automatic random_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned n);
        int unsigned goal;
        goal = useful_items + n;
        set_idling(send_pct, recv_pct);
        while (useful_items < goal)
        begin
            random_token();
            pump();
        end
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 350);
        random_phase(73, 0, 350);
        random_phase(0, 73, 350);
        random_phase(27, 27, 350);
    endtask

    // receiver holds off while items keep coming, so item_ready has to drop
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_target = hold_target + 400;
        for (int i = 0; i < 50; i++)
            put_literal($urandom_range(255));
        pump();
    endtask

    // long copy through many all-ones groups, at full rate with offset one
    task automatic test_long_copy();
        set_idling(0, 0);
        put_literal($urandom_range(255));
        put_match(1, 8 + 15 * 12 + 3, 1'b1);
        pump();
    endtask

    // largest and smallest offsets of both forms
    task automatic test_offset_extremes();
        set_idling(27, 27);
        put_match(2047, 3, 1'b0);
        put_match(127, 2, 1'b1);
        put_match(1, 4, 1'b0);
        put_match(1, 2, 1'b1);
        pump();
    endtask

    // end marker with trailing bits dropped, then items that must all be refused
    task automatic test_end_marker();
        set_idling(0, 0);
        put_literal($urandom_range(255));
        put_field(3, 2);
        put_field(0, 7);
        while (stream_bits.size() % 8 != 0)
            stream_bits.insert(stream_bits.size(), 1'($urandom_range(1)));
        pump();
        for (int i = 0; i < 6; i++)
            send_item(i[0] ? OP_ADVANCE : OP_FEED, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_model();
        send_idle_pct = 0;
        stall_pct     = 0;
        noise_pct     = 5;
        hold_target   = 0;
        hold_count    = 0;
        useful_items  = 0;
        error_count   = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals();
        test_match_lengths();
        test_bad_offsets();
        test_random_traffic();
        test_backpressure();
        test_long_copy();
        test_offset_extremes();
        test_end_marker();

        // let the pipeline drain, then wait on for any stray result
        item_valid <= 1'b0;
        set_idling(0, 0);
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (error_count == 0 && decoded_queue.size() == 0)
            $display("lzs_stream_decompressor test passed");
        else
            $display("lzs_stream_decompressor test failed");
        $finish;
    end

    // hang guard, far above the slowest correct run
    initial
    begin
        #4ms;
        $display("lzs_stream_decompressor test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/lzs_pkg.sv
rtl/lzs_ram.sv
rtl/lzs_decoder.sv
rtl/lzs_stream_decompressor.sv
tb/lzs_stream_decompressor_test.sv
